[src/qym_pkg.sv]
// Shared types and constants for the yaw-rate motor mixer.
// Used by every module of the block; depends on nothing.
package qym_pkg;

   // register indexes on the csr port
   localparam logic [7:0] REG_WEIGHT_RP  = 8'd0;
   localparam logic [7:0] REG_WEIGHT_L   = 8'd1;
   localparam logic [7:0] REG_WEIGHT_Y   = 8'd2;
   localparam logic [7:0] REG_YAW_GAIN   = 8'd3;
   localparam logic [7:0] REG_TRIM_ROLL  = 8'd4;
   localparam logic [7:0] REG_TRIM_PITCH = 8'd5;
   localparam logic [7:0] REG_TRIM_YAW   = 8'd6;
   localparam logic [7:0] REG_TRIM_LIFT  = 8'd7;

   // speed limits in sum units (speed * 32)
   localparam logic signed [17:0] SPEED_LO = 18'sd5760;   // 180 * 32
   localparam logic signed [17:0] SPEED_HI = 18'sd22400;  // 700 * 32

   localparam int SUM_W = 37;  // width of a motor sum
   localparam int Q_W   = 15;  // quotient bits kept; larger values saturate

   typedef struct packed {
      logic [7:0]         wrp;
      logic [7:0]         wl;
      logic [7:0]         wy;
      logic [7:0]         gain;       // zero already mapped to one
      logic signed [15:0] trim_roll;
      logic signed [15:0] trim_pitch;
      logic signed [15:0] trim_yaw;
      logic signed [15:0] trim_lift;
      logic [9:0]         total;      // wl + 2*wrp + wy, zero mapped to one
   } cfg_type;

endpackage

[src/qym_csr.sv]
// Configuration registers of the mixer, written through the csr port.
// Depends on qym_pkg.
module qym_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_data,
   output qym_pkg::cfg_type   cfg
);
   import qym_pkg::*;

   logic [7:0]         wrp_ff, wl_ff, wy_ff, gain_ff;
   logic signed [15:0] tr_ff, tp_ff, ty_ff, tl_ff;
   logic [9:0]         total;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrp_ff  <= 8'd9;
         wl_ff   <= 8'd27;
         wy_ff   <= 8'd18;
         gain_ff <= 8'd1;
         tr_ff   <= '0;
         tp_ff   <= '0;
         ty_ff   <= '0;
         tl_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WEIGHT_RP:  wrp_ff  <= csr_data[7:0];
            REG_WEIGHT_L:   wl_ff   <= csr_data[7:0];
            REG_WEIGHT_Y:   wy_ff   <= csr_data[7:0];
            REG_YAW_GAIN:   gain_ff <= csr_data[7:0];
            REG_TRIM_ROLL:  tr_ff   <= csr_data;
            REG_TRIM_PITCH: tp_ff   <= csr_data;
            REG_TRIM_YAW:   ty_ff   <= csr_data;
            REG_TRIM_LIFT:  tl_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign total = 10'(wl_ff) + {1'b0, wrp_ff, 1'b0} + 10'(wy_ff);

   always_comb begin
      cfg.wrp        = wrp_ff;
      cfg.wl         = wl_ff;
      cfg.wy         = wy_ff;
      cfg.gain       = (gain_ff == 8'd0) ? 8'd1 : gain_ff;
      cfg.trim_roll  = tr_ff;
      cfg.trim_pitch = tp_ff;
      cfg.trim_yaw   = ty_ff;
      cfg.trim_lift  = tl_ff;
      cfg.total      = (total == 10'd0) ? 10'd1 : total;
   end

endmodule

[src/qym_ydiv.sv]
// Four-stage restoring divider: 16-bit magnitude by 8-bit gain, 4 bits a stage.
// Depends on qym_pkg.
module qym_ydiv (
   input  logic        clock,
   input  logic        enable,
   input  logic [15:0] mag_i,
   input  logic [7:0]  gain_i,
   output logic [15:0] q_o
);
   import qym_pkg::*;

   logic [15:0] dq_ff [4];
   logic [7:0]  rem_ff [4];
   logic [15:0] dq_in [4];
   logic [7:0]  rem_in [4];
   logic [15:0] dq_src [4];
   logic [7:0]  rem_src [4];

   always_comb begin
      logic [15:0] d;
      logic [8:0]  t;
      logic [7:0]  r;
      dq_src[0]  = mag_i;
      rem_src[0] = '0;
      for (int s = 1; s < 4; s++) begin
         dq_src[s]  = dq_ff[s-1];
         rem_src[s] = rem_ff[s-1];
      end
      for (int s = 0; s < 4; s++) begin
         d = dq_src[s];
         r = rem_src[s];
         for (int b = 0; b < 4; b++) begin
            t = {r, d[15]};
            d = {d[14:0], 1'b0};
            if (t >= {1'b0, gain_i}) begin
               t    = t - {1'b0, gain_i};
               d[0] = 1'b1;
            end
            r = t[7:0];
         end
         dq_in[s]  = d;
         rem_in[s] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < 4; s++) begin
            dq_ff[s]  <= dq_in[s];
            rem_ff[s] <= rem_in[s];
         end
      end
   end

   assign q_o = dq_ff[3];

endmodule

[src/qym_sdiv.sv]
// Four-stage divider of one motor sum by the total weight, saturating quotient.
// Depends on qym_pkg.
module qym_sdiv (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [qym_pkg::SUM_W-1:0]  sum_i,
   input  logic [9:0]                        total_i,
   output logic [qym_pkg::Q_W-1:0]           q_o
);
   import qym_pkg::*;

   logic [Q_W-1:0] dq_ff [4];
   logic [9:0]     rem_ff [4];
   logic [1:0]     flag_ff [4];   // {saturate, non-positive}
   logic [Q_W-1:0] dq_in [4];
   logic [9:0]     rem_in [4];
   logic [Q_W-1:0] dq_src [4];
   logic [9:0]     rem_src [4];
   logic [1:0]     flag_src [4];
   logic           neg, sat;

   assign neg = (sum_i <= 0);
   assign sat = !neg && (sum_i >= $signed({12'd0, total_i, 15'd0}));

   always_comb begin
      logic [Q_W-1:0] d;
      logic [10:0]    t;
      logic [9:0]     r;
      dq_src[0]   = sum_i[Q_W-1:0];
      rem_src[0]  = sum_i[24:15];
      flag_src[0] = {sat, neg};
      for (int s = 1; s < 4; s++) begin
         dq_src[s]   = dq_ff[s-1];
         rem_src[s]  = rem_ff[s-1];
         flag_src[s] = flag_ff[s-1];
      end
      for (int s = 0; s < 4; s++) begin
         d = dq_src[s];
         r = rem_src[s];
         for (int b = 0; b < 4; b++) begin
            if (s * 4 + b < Q_W) begin
               t = {r, d[Q_W-1]};
               d = {d[Q_W-2:0], 1'b0};
               if (t >= {1'b0, total_i}) begin
                  t    = t - {1'b0, total_i};
                  d[0] = 1'b1;
               end
               r = t[9:0];
            end
         end
         dq_in[s]  = d;
         rem_in[s] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < 4; s++) begin
            dq_ff[s]   <= dq_in[s];
            rem_ff[s]  <= rem_in[s];
            flag_ff[s] <= flag_src[s];
         end
      end
   end

   assign q_o = flag_ff[3][0] ? '0 : (flag_ff[3][1] ? '1 : dq_ff[3]);

endmodule

[src/quad_yaw_rate_motor_mixer.sv]
// Top level of the plus-layout quad motor mixer with yaw-rate P control.
// Depends on qym_pkg, qym_csr, qym_ydiv and qym_sdiv.

// A request word carries one sample of sticks and gyro yaw rate; one response
// word with four motor speeds (0..700) comes back for each, in order. The
// block is a 14-stage pipeline: input capture, four stages of the yaw
// divider (stick / gain), gain multiply, yaw trim, axis weighting, motor sums,
// four stages of the total-weight dividers (one divider per motor, all four in
// parallel), and the output register. It accepts a word every cycle while the
// output is taken. The whole pipeline moves together and holds when the output
// word is not taken, so req_tready is low only while rsp_tvalid is high and
// rsp_tready is low.
// Registers are written on the csr port, which is always ready; write them
// only while the pipeline is empty.
module quad_yaw_rate_motor_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // roll_stick, pitch_stick, yaw_stick, lift_stick, yaw_rate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // motor_0, motor_1, motor_2, motor_3
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);
   import qym_pkg::*;

   // per-sample data that rides alongside the yaw divider
   typedef struct packed {
      logic signed [16:0] ar;
      logic signed [16:0] ap;
      logic signed [17:0] al;
      logic signed [15:0] rate;
      logic               yneg;
   } side_type;

   cfg_type cfg;
   logic    adv;   // whole pipeline advances

   logic [12:0] vld_ff;   // stages 1..13
   logic [12:0] vld_in;

   qym_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      vld_in = {vld_ff[11:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_tvalid <= 1'b0;
      end else if (adv) begin
         vld_ff     <= vld_in;
         rsp_tvalid <= vld_ff[12];
      end
   end

   // ---- stage 1: unpack, lift inversion, trims, yaw magnitude
   logic signed [15:0] roll, pitch, yaw, lift, rate;
   logic signed [17:0] linv;
   side_type           side_in;
   logic [15:0]        ymag_in, ymag_ff;
   side_type           side_ff [5];

   assign roll  = req_tdata[15:0];
   assign pitch = req_tdata[31:16];
   assign yaw   = req_tdata[47:32];
   assign lift  = req_tdata[63:48];
   assign rate  = req_tdata[79:64];

   always_comb begin
      linv         = 18'sd32767 - 18'(lift);   // 0..65535
      side_in.ar   = 17'(roll) + 17'(cfg.trim_roll);
      side_in.ap   = 17'(pitch) + 17'(cfg.trim_pitch);
      side_in.al   = $signed({3'b0, linv[15:1]}) + 18'(cfg.trim_lift);
      side_in.rate = rate;
      side_in.yneg = yaw[15];
      ymag_in      = yaw[15] ? 16'(-yaw) : yaw;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ymag_ff    <= ymag_in;
         side_ff[0] <= side_in;
         for (int s = 1; s < 5; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // ---- stages 2..5: yaw stick / gain, magnitude only
   logic [15:0] yq;

   qym_ydiv u_ydiv (
      .clock  (clock),
      .enable (adv),
      .mag_i  (ymag_ff),
      .gain_i (cfg.gain),
      .q_o    (yq)
   );

   // ---- stage 6: restore sign, subtract rate, multiply by gain
   logic signed [16:0] yqs;
   logic signed [17:0] ydiff;
   logic signed [25:0] ycmd_in, ycmd_ff;
   logic signed [16:0] ar6_ff, ap6_ff, ar7_ff, ap7_ff;
   logic signed [17:0] al6_ff, al7_ff, al8_ff;

   always_comb begin
      yqs     = side_ff[4].yneg ? -$signed({1'b0, yq}) : $signed({1'b0, yq});
      ydiff   = 18'(yqs) - 18'(side_ff[4].rate);
      ycmd_in = 26'(ydiff) * $signed({18'd0, cfg.gain});
   end

   // ---- stage 7: yaw trim
   logic signed [26:0] ay_ff;

   // ---- stage 8: axis weighting
   logic signed [25:0] base_ff;
   logic signed [25:0] rt_ff, pt_ff;
   logic signed [35:0] yt_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ycmd_ff <= ycmd_in;
         ar6_ff  <= side_ff[4].ar;
         ap6_ff  <= side_ff[4].ap;
         al6_ff  <= side_ff[4].al;

         ay_ff   <= 27'(ycmd_ff) + 27'(cfg.trim_yaw);
         ar7_ff  <= ar6_ff;
         ap7_ff  <= ap6_ff;
         al7_ff  <= al6_ff;

         base_ff <= 26'(al7_ff) * $signed({18'd0, cfg.wl});
         rt_ff   <= 26'(ar7_ff) * $signed({18'd0, cfg.wrp});
         pt_ff   <= 26'(ap7_ff) * $signed({18'd0, cfg.wrp});
         yt_ff   <= 36'(ay_ff) * $signed({28'd0, cfg.wy});
         al8_ff  <= al7_ff;
      end
   end

   // ---- stage 9: four motor sums
   logic signed [SUM_W-1:0] b9, r9, p9, y9;
   logic signed [SUM_W-1:0] sum_ff [4];
   logic signed [17:0]      al_d_ff [5];   // stages 9..13

   always_comb begin
      b9 = SUM_W'(base_ff);
      r9 = SUM_W'(rt_ff) <<< 1;
      p9 = SUM_W'(pt_ff) <<< 1;
      y9 = SUM_W'(yt_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff[0]  <= b9 + p9 - y9;
         sum_ff[1]  <= b9 - r9 + y9;
         sum_ff[2]  <= b9 - p9 - y9;
         sum_ff[3]  <= b9 + r9 + y9;
         al_d_ff[0] <= al8_ff;
         for (int s = 1; s < 5; s++) al_d_ff[s] <= al_d_ff[s-1];
      end
   end

   // ---- stages 10..13: divide by total weight
   logic [Q_W-1:0] mq [4];

   for (genvar m = 0; m < 4; m++) begin : g_div
      qym_sdiv u_sdiv (
         .clock   (clock),
         .enable  (adv),
         .sum_i   (sum_ff[m]),
         .total_i (cfg.total),
         .q_o     (mq[m])
      );
   end

   // ---- stage 14: minimum substitution, cap, scale by 1/32
   logic [39:0] rsp_in;

   always_comb begin
      logic signed [17:0] v;
      for (int m = 0; m < 4; m++) begin
         v = $signed({3'b0, mq[m]});
         if (v < SPEED_LO) begin
            v = (al_d_ff[4] < SPEED_LO) ? al_d_ff[4] : SPEED_LO;
         end else if (v > SPEED_HI) begin
            v = SPEED_HI;
         end
         rsp_in[m*10 +: 10] = v[17] ? 10'd0 : v[14:5];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata <= rsp_in;
      end
   end

endmodule
